FILE: design/rals_pkg.sv
// ----------------------------------------------------------------------------
// rals_pkg: shared types and constants for the RGB auto-levels stretch
// Pixel layout, command codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package rals_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned NUM_CH   = 3;             // red, green, blue
  localparam int unsigned TDATA_W  = 4 * PIX_W;     // red, green, blue, alpha
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned NUM_W    = 2 * PIX_W;     // (value - low) * 255
  localparam int unsigned DIV_STEPS = PIX_W;        // one quotient bit per step
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;

  // Command codes carried on tuser
  localparam logic [CMD_W-1:0] CMD_MEAS_FIRST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MEAS_MORE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CORRECT    = 2'd2;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  // Controller to datapath commands
  typedef struct packed {
    logic meas_first;   // restart min/max from this pixel
    logic meas_more;    // widen min/max with this pixel
    logic load;         // capture a correct pixel and set up the divide
    logic step;         // one restoring divide iteration on all channels
    logic out_load;     // finish and move the result to the output register
  } rals_cmd_t;

endpackage

FILE: design/rgb_auto_levels_stretch.sv
// ----------------------------------------------------------------------------
// rgb_auto_levels_stretch: per-channel auto-levels contrast stretch
// Measures RGB min/max over measure pixels and stretches correct pixels to
// the full 0..255 range, with an optional blue clamp; alpha passes through.
//
//   channel  | direction | transfer moves
//   s_axis   | in        | one pixel with its command
//   m_axis   | out       | one stretched pixel (correct pixels only)
//   cfg      | in        | blue clamp enable write
//
// A measure pixel is handled as it is accepted. A correct pixel runs load,
// 8 iterations of the shared-step restoring divider (one quotient bit each,
// three channel lanes in parallel), and a finish state into the output reg.
// The finish state waits while an earlier result has not been taken; input
// is accepted again once the result is in the output register. Reset clears
// the measured range to zero and sets the blue clamp enable.
// ----------------------------------------------------------------------------
module rgb_auto_levels_stretch (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,      // blue_clamp_enable
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [rals_pkg::TDATA_W-1:0] s_axis_tdata_i,   // red_in, green_in, blue_in, alpha_in
  input  logic [rals_pkg::CMD_W-1:0]   s_axis_tuser_i,   // cmd
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [rals_pkg::TDATA_W-1:0] m_axis_tdata_o    // red_out, green_out, blue_out, alpha_out
);
  import rals_pkg::*;

  rals_cmd_t cmd;

  rals_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cmd_o           (cmd)
  );

  rals_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .pix_i       (s_axis_tdata_i),
    .pix_o       (m_axis_tdata_o)
  );

endmodule

FILE: design/rals_ctrl.sv
// ----------------------------------------------------------------------------
// rals_ctrl: sequencing controller
// Accepts pixels, runs the divide iterations and owns the output valid flag.
// ----------------------------------------------------------------------------
module rals_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [rals_pkg::CMD_W-1:0] s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output rals_pkg::rals_cmd_t       cmd_o
);
  import rals_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              out_valid_q, out_valid_d;
  logic              in_xfer;
  logic              out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;

  // Decode commands and next state
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (s_axis_tuser_i)
            CMD_MEAS_FIRST: cmd_o.meas_first = 1'b1;
            CMD_MEAS_MORE:  cmd_o.meas_more  = 1'b1;
            CMD_CORRECT: begin
              cmd_o.load = 1'b1;
              step_d     = '0;
              state_d    = ST_DIV;
            end
            default: ;  // unused code: drop the pixel
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: design/rals_datapath.sv
// ----------------------------------------------------------------------------
// rals_datapath: min/max registers, per-channel dividers, output register
// Three restoring divider lanes compute (value - low) * 255 / (high - low).
// ----------------------------------------------------------------------------
module rals_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  rals_pkg::rals_cmd_t         cmd_i,
  input  logic [rals_pkg::TDATA_W-1:0] pix_i,
  output logic [rals_pkg::TDATA_W-1:0] pix_o
);
  import rals_pkg::*;

  logic [PIX_W-1:0] lo_q   [NUM_CH];
  logic [PIX_W-1:0] hi_q   [NUM_CH];
  logic [PIX_W-1:0] val    [NUM_CH];
  logic             clamp_q;

  // Divider lane registers
  logic [PIX_W-1:0] span_q [NUM_CH];
  logic [PIX_W-1:0] rem_q  [NUM_CH];
  logic [PIX_W-1:0] low_q  [NUM_CH];   // numerator bits still to shift in
  logic [PIX_W-1:0] quo_q  [NUM_CH];
  logic             zero_q [NUM_CH];
  logic             sat_q  [NUM_CH];
  logic [PIX_W-1:0] alpha_q;
  logic [TDATA_W-1:0] out_q;

  logic [NUM_W-1:0] num    [NUM_CH];
  logic [PIX_W:0]   trial  [NUM_CH];
  logic             ge     [NUM_CH];
  logic [PIX_W-1:0] res    [NUM_CH];
  logic [PIX_W-1:0] blue_fin;

  // Split the pixel and form numerators and trial subtractions
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      val[c]   = pix_i[c*PIX_W +: PIX_W];
      num[c]   = ({val[c] - lo_q[c], {PIX_W{1'b0}}}) - NUM_W'(val[c] - lo_q[c]);
      trial[c] = {rem_q[c], low_q[c][PIX_W-1]};
      ge[c]    = (trial[c] >= {1'b0, span_q[c]});
      if (zero_q[c]) begin
        res[c] = '0;
      end else if (sat_q[c]) begin
        res[c] = FULL_SCALE;
      end else begin
        res[c] = quo_q[c];
      end
    end
    blue_fin = res[2];
    if (clamp_q && (res[2] > res[0]) && (res[2] > res[1])) begin
      blue_fin = res[1];
    end
  end

  // Measured range and config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_q <= 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        lo_q[c] <= '0;
        hi_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        clamp_q <= cfg_wdata_i;
      end
      for (int c = 0; c < NUM_CH; c++) begin
        if (cmd_i.meas_first) begin
          lo_q[c] <= val[c];
          hi_q[c] <= val[c];
        end else if (cmd_i.meas_more) begin
          if (val[c] < lo_q[c]) lo_q[c] <= val[c];
          if (val[c] > hi_q[c]) hi_q[c] <= val[c];
        end
      end
    end
  end

  // Divider lanes and output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      alpha_q <= pix_i[3*PIX_W +: PIX_W];
    end
    for (int c = 0; c < NUM_CH; c++) begin
      if (cmd_i.load) begin
        span_q[c] <= hi_q[c] - lo_q[c];
        // high byte of the numerator is below the span, so 8 steps suffice
        rem_q[c]  <= num[c][NUM_W-1:PIX_W];
        low_q[c]  <= num[c][PIX_W-1:0];
        quo_q[c]  <= '0;
        zero_q[c] <= (hi_q[c] <= lo_q[c]) || (val[c] <= lo_q[c]);
        sat_q[c]  <= (val[c] >= hi_q[c]);
      end else if (cmd_i.step) begin
        rem_q[c]  <= ge[c] ? PIX_W'(trial[c] - {1'b0, span_q[c]}) : trial[c][PIX_W-1:0];
        low_q[c]  <= {low_q[c][PIX_W-2:0], 1'b0};
        quo_q[c]  <= {quo_q[c][PIX_W-2:0], ge[c]};
      end
    end
    if (cmd_i.out_load) begin
      out_q <= {alpha_q, blue_fin, res[1], res[0]};
    end
  end

  assign pix_o = out_q;

endmodule
